/* hdl/tga_pkg.sv */
`timescale 1ns / 1ps
package tga_pkg;

    typedef struct packed {
        logic       first;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [14:0] dest_row;
        logic [14:0] start_col;
        logic [7:0]  run_length;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_PACKET = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_IDLE   = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_RUN    = 2'd0;
    localparam logic [1:0] KIND_HDR_OK = 2'd1;
    localparam logic [1:0] KIND_HDR_ER = 2'd2;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_CMAP  = 3'd1;
    localparam logic [2:0] ERR_TYPE  = 3'd2;
    localparam logic [2:0] ERR_DIM   = 3'd3;
    localparam logic [2:0] ERR_DEPTH = 3'd4;
    localparam logic [2:0] ERR_ORIG  = 3'd5;

    localparam int QDEPTH = 2;

    function automatic logic pow2_ok(input logic [15:0] v);
        return (v != 16'd0) && ((v & (v - 16'd1)) == 16'd0);
    endfunction

endpackage

/* hdl/tga_fifo.sv */
`timescale 1ns / 1ps
module tga_fifo
    import tga_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_in_word  o_data
);
    t_in_word r_mem [QDEPTH];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QDEPTH)) else $error("fifo count overflow");
    cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd && r_cnt < 2'(QDEPTH)) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("fifo count not incremented");
    cnt_dn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd && !wr) |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("fifo count not decremented");
endmodule

/* hdl/tga_dec.sv */
`timescale 1ns / 1ps
module tga_dec
    import tga_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    t_phase      r_phase, n_phase;
    logic [4:0]  r_hidx, n_hidx;
    logic [7:0]  r_idrem, n_idrem;
    logic        r_rle, n_rle, r_alpha, n_alpha, r_bu, n_bu;
    logic [15:0] r_w, n_w, r_h, n_h, r_col, n_col, r_rows, n_rows;
    logic [7:0]  r_pl, n_pl;
    logic        r_rep, n_rep;
    logic [1:0]  r_pbi, n_pbi;
    logic [23:0] r_ch, n_ch;
    logic [3:0]  r_wlog, n_wlog;
    // remaining pixels tracked as count down
    logic [31:0] r_left, n_left;

    logic      r_ov;
    t_out_word r_out, n_out;
    logic      emit, take;
    t_phase    ph;
    logic [4:0] hidx;
    logic [7:0] b;
    logic [31:0] rn, sum;
    logic [2:0]  need;

    assign o_ready = !r_ov || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign b       = i_data.data_byte;

    always_comb begin
        n_phase = r_phase; n_hidx = r_hidx; n_idrem = r_idrem; n_rle = r_rle;
        n_alpha = r_alpha; n_bu = r_bu; n_w = r_w; n_h = r_h; n_col = r_col;
        n_rows = r_rows; n_pl = r_pl; n_rep = r_rep; n_pbi = r_pbi; n_ch = r_ch;
        n_wlog = r_wlog; n_left = r_left;
        n_out = '0; emit = 1'b0;
        ph = r_phase; hidx = r_hidx;
        rn = 32'd1; sum = 32'd0;
        need = r_alpha ? 3'd4 : 3'd3;
        if (i_data.first) begin
            ph = PH_HEADER; hidx = 5'd0; n_phase = PH_HEADER;
        end
        case (ph)
            PH_HEADER: begin
                if (hidx < 5'd31) n_hidx = hidx + 5'd1; else n_hidx = hidx;
                case (hidx)
                    5'd0: n_idrem = b;
                    5'd1: if (b != 8'd0) begin
                        emit = 1'b1; n_out.kind = KIND_HDR_ER;
                        n_out.error_code = ERR_CMAP; n_phase = PH_IDLE;
                    end
                    5'd2: if (b != 8'd2 && b != 8'd10) begin
                        emit = 1'b1; n_out.kind = KIND_HDR_ER;
                        n_out.error_code = ERR_TYPE; n_phase = PH_IDLE;
                    end else n_rle = (b == 8'd10);
                    5'd12: n_w = {8'd0, b};
                    5'd13: n_w = {b, r_w[7:0]};
                    5'd14: n_h = {8'd0, b};
                    5'd15: begin
                        n_h = {b, r_h[7:0]};
                        if (!pow2_ok(r_w) || !pow2_ok(n_h)) begin
                            emit = 1'b1; n_out.kind = KIND_HDR_ER;
                            n_out.error_code = ERR_DIM; n_phase = PH_IDLE;
                        end
                        n_wlog = 4'd0;
                        for (int k = 0; k < 16; k++)
                            if (r_w[k]) n_wlog = 4'(k);
                        // power-of-two sizes: total = 1 << (log w + log h)
                        n_left = 32'd0;
                        for (int k = 0; k < 16; k++)
                            if (n_h[k]) n_left = {16'd0, r_w} << k;
                    end
                    5'd16: if (b != 8'd32 && b != 8'd24) begin
                        emit = 1'b1; n_out.kind = KIND_HDR_ER;
                        n_out.error_code = ERR_DEPTH; n_phase = PH_IDLE;
                    end else n_alpha = (b == 8'd32);
                    5'd17: if (b[4]) begin
                        emit = 1'b1; n_out.kind = KIND_HDR_ER;
                        n_out.error_code = ERR_ORIG; n_phase = PH_IDLE;
                    end else begin
                        n_bu = !b[5];
                        emit = 1'b1; n_out.kind = KIND_HDR_OK;
                        n_out.image_width = r_w; n_out.image_height = r_h;
                        n_col = 16'd0; n_rows = 16'd0; n_pl = 8'd0;
                        n_rep = 1'b0; n_pbi = 2'd0;
                        if (r_idrem != 8'd0) n_phase = PH_IDSKIP;
                        else n_phase = r_rle ? PH_PACKET : PH_PIXEL;
                    end
                    default: ;
                endcase
            end
            PH_IDSKIP: begin
                n_idrem = r_idrem - 8'd1;
                if (n_idrem == 8'd0) begin
                    n_col = 16'd0; n_rows = 16'd0; n_pl = 8'd0;
                    n_rep = 1'b0; n_pbi = 2'd0;
                    n_phase = r_rle ? PH_PACKET : PH_PIXEL;
                end
            end
            PH_PACKET: begin
                n_rep = b[7];
                n_pl = b[7] ? ({1'b0, b[6:0]} + 8'd1) : (b + 8'd1);
                n_pbi = 2'd0;
                n_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                case (r_pbi)
                    2'd0: n_ch[7:0] = b;
                    2'd1: n_ch[15:8] = b;
                    2'd2: n_ch[23:16] = b;
                    default: ;
                endcase
                if (3'(r_pbi) + 3'd1 < need) begin
                    n_pbi = r_pbi + 2'd1;
                end else begin
                    n_pbi = 2'd0;
                    if (r_left == 32'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        if (r_rle && r_rep && r_pl != 8'd0) rn = {24'd0, r_pl};
                        if (rn > r_left) rn = r_left;
                        emit = 1'b1;
                        n_out.kind = KIND_RUN;
                        n_out.dest_row = r_bu ? 15'(r_h - 16'd1 - r_rows)
                                              : r_rows[14:0];
                        n_out.start_col = r_col[14:0];
                        n_out.run_length = rn[7:0];
                        n_out.red = n_ch[23:16];
                        n_out.green = n_ch[15:8];
                        n_out.blue = n_ch[7:0];
                        n_out.alpha = r_alpha ? b : 8'hFF;
                        n_out.last = (rn == r_left);
                        n_left = r_left - rn;
                        sum = {16'd0, r_col} + rn;
                        n_rows = r_rows + 16'(sum >> r_wlog);
                        n_col = 16'(sum & ({16'd0, r_w} - 32'd1));
                        if (rn == r_left) n_phase = PH_IDLE;
                        else if (r_rle) begin
                            if (r_rep) begin
                                n_pl = 8'd0; n_phase = PH_PACKET;
                            end else begin
                                if (r_pl != 8'd0) n_pl = r_pl - 8'd1;
                                if (n_pl == 8'd0) n_phase = PH_PACKET;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hidx <= 5'd0; r_idrem <= 8'd0;
            r_rle <= 1'b0; r_alpha <= 1'b0; r_bu <= 1'b1;
            r_w <= 16'd0; r_h <= 16'd0; r_col <= 16'd0; r_rows <= 16'd0;
            r_pl <= 8'd0; r_rep <= 1'b0; r_pbi <= 2'd0; r_ch <= 24'd0;
            r_wlog <= 4'd0; r_left <= 32'd0; r_ov <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_hidx <= n_hidx; r_idrem <= n_idrem;
                r_rle <= n_rle; r_alpha <= n_alpha; r_bu <= n_bu;
                r_w <= n_w; r_h <= n_h; r_col <= n_col; r_rows <= n_rows;
                r_pl <= n_pl; r_rep <= n_rep; r_pbi <= n_pbi; r_ch <= n_ch;
                r_wlog <= n_wlog; r_left <= n_left;
            end
            if (take && emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) r_out <= n_out;
    end

    out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov && $stable(r_out))
        else $error("result dropped under stall");
    pbi_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL) |-> (r_pbi != 2'd3 || r_alpha))
        else $error("byte index past pixel size");
    idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_IDLE && !i_data.first) |=> !($rose(r_ov)))
        else $error("result from idle phase");
endmodule

/* hdl/tga_rle_image_decoder_core.sv */
`timescale 1ns / 1ps
// Channel | Direction | Signals
// input   | in        | i_valid, o_ready, i_data (t_in_word)
// result  | out       | o_valid, i_ready, o_data (t_out_word)
// One byte per cycle sustained while the output does not stall; each byte is
// registered in a two-entry queue that parts the byte front from the decoder;
// results sit in an output register, so a stalled output stalls the decoder,
// then fills the queue. Synchronous active-low reset.
module tga_rle_image_decoder_core
    import tga_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    logic     q_valid, q_ready;
    t_in_word q_data;

    tga_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_data,
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    tga_dec u_dec (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_data(q_data),
        .o_valid, .i_ready, .o_data
    );
endmodule
